// ===== rtl/sqs_pkg.sv =====
// ----------------------------------------------------------------------------
// sqs_pkg
// Shared widths, reset values, register indexes and control types for the
// square, glide and noise clip generator.
// ----------------------------------------------------------------------------
package sqs_pkg;

   localparam int unsigned NOISE_HOLD_DEF = 8;
   localparam int unsigned PHASE_BITS_DEF = 24;

   localparam int unsigned STEP_W       = 24;
   localparam int unsigned SAMPLE_W     = 16;
   localparam int unsigned AMP_W        = 15;
   localparam int unsigned LEN_W        = 16;
   localparam int unsigned DUTY_W       = 9;
   localparam int unsigned DUTY_FRAC_W  = 8;
   localparam int unsigned MODE_W       = 2;
   localparam int unsigned LFSR_W       = 16;
   localparam int unsigned NOISE_W      = 17;
   localparam int unsigned CSR_IDX_W    = 3;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned MUL_A_W      = 31;
   localparam int unsigned MUL_B_W      = 16;
   localparam int unsigned PROD_W       = MUL_A_W + MUL_B_W;
   localparam int unsigned DVS_W        = 32;
   localparam int unsigned QUO_W        = 24;

   localparam logic [LFSR_W-1:0]  LFSR_TAPS   = 16'hB400;
   localparam logic [LFSR_W-1:0]  LFSR_RESET  = 16'd44257;
   localparam logic [NOISE_W:0]   NOISE_FULL  = 18'd65535;

   localparam logic [MODE_W-1:0]  MODE_RESET  = 2'd0;
   localparam logic [DUTY_W-1:0]  DUTY_RESET  = 9'd128;
   localparam logic [AMP_W-1:0]   AMP_RESET   = 15'd6553;
   localparam logic [LEN_W-1:0]   LEN_RESET   = 16'd2205;
   localparam logic [LFSR_W-1:0]  SEED_RESET  = 16'd44257;

   localparam logic [MODE_W-1:0]  MODE_CONST  = 2'd0;
   localparam logic [MODE_W-1:0]  MODE_GLIDE  = 2'd1;
   localparam logic [MODE_W-1:0]  MODE_NOISE  = 2'd2;

   localparam logic               CMD_TICK    = 1'b0;
   localparam logic               CMD_START   = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE        = 3'd0,
      CSR_DUTY        = 3'd1,
      CSR_AMPLITUDE   = 3'd2,
      CSR_NOTE_LENGTH = 3'd3,
      CSR_NOISE_SEED  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_CONST,
      KIND_GLIDE,
      KIND_NOISE
   } kind_type;

   typedef enum logic [1:0] {
      MUL_AMP_REM,
      MUL_GLIDE,
      MUL_NOISE_AMP,
      MUL_PROD_REM
   } mul_sel_type;

   typedef struct packed {
      logic        accept_start;
      logic        accept_tick;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_start;
      logic        div_scaled;
      logic        glide_add;
      logic        load_mag;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic     playing;
      kind_type kind;
      logic     div_done;
   } dp_status_type;

endpackage

// ===== rtl/sqs_if.sv =====
// ----------------------------------------------------------------------------
// sqs_if
// Valid/ready channels: command items in, sample items out.
// ----------------------------------------------------------------------------
interface sqs_req_if;
   import sqs_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [STEP_W-1:0] start_step;
   logic [STEP_W-1:0] end_step;

   modport source (output valid, command, start_step, end_step, input ready);
   modport sink   (input valid, command, start_step, end_step, output ready);
endinterface

interface sqs_rsp_if;
   import sqs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_of_note;
   logic                       active;

   modport source (output valid, sample, last_of_note, active, input ready);
   modport sink   (input valid, sample, last_of_note, active, output ready);
endinterface

// ===== rtl/sqs_div.sv =====
// ----------------------------------------------------------------------------
// sqs_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QUO_W bits, so the top dividend bits start as the partial remainder.
// ----------------------------------------------------------------------------
module sqs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sqs_pkg::PROD_W-1:0]  dividend,
   input  logic [sqs_pkg::DVS_W-1:0]   divisor,
   output logic                        done,
   output logic [sqs_pkg::QUO_W-1:0]   quotient
);
   import sqs_pkg::*;

   localparam int unsigned CNT_W = $clog2(QUO_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0] dvq_ff, dvq_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;
   logic             last_step;

   assign trial     = {rem_ff, dvq_ff[QUO_W-1]};
   assign diff      = trial - {1'b0, dvs_ff};
   assign fits      = ~diff[DVS_W];
   assign last_step = (cnt_ff == CNT_W'(QUO_W - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvq_in  = dvq_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DVS_W'(dividend[PROD_W-1:QUO_W]);
         dvq_in  = dividend[QUO_W-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         dvq_in = {dvq_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvq_ff <= dvq_in;
   end

   assign done     = done_ff;
   assign quotient = dvq_ff;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && last_step && !start) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after last step");
   a_done_from_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
`endif

endmodule

// ===== rtl/sqs_dp.sv =====
// ----------------------------------------------------------------------------
// sqs_dp
// Datapath: control registers, note state, phase and noise generators,
// shared multiplier, divider and the output register.
// ----------------------------------------------------------------------------
module sqs_dp #(
   parameter int unsigned NOISE_HOLD = sqs_pkg::NOISE_HOLD_DEF,
   parameter int unsigned PHASE_BITS = sqs_pkg::PHASE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [sqs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sqs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [sqs_pkg::STEP_W-1:0]        req_start_step,
   input  logic [sqs_pkg::STEP_W-1:0]        req_end_step,
   input  sqs_pkg::dp_cmd_type               cmd,
   output sqs_pkg::dp_status_type            status,
   output logic signed [sqs_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                              rsp_last_of_note,
   output logic                              rsp_active
);
   import sqs_pkg::*;

   localparam int unsigned HOLD_W = (NOISE_HOLD > 1) ? $clog2(NOISE_HOLD) : 1;

   // control registers
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;
   logic [AMP_W-1:0]    amp_ff, amp_in;
   logic [LEN_W-1:0]    note_len_ff, note_len_in;
   logic [LFSR_W-1:0]   seed_ff, seed_in;

   // note state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [LEN_W-1:0]      idx_ff, idx_in;
   logic                  playing_ff, playing_in;
   logic [STEP_W-1:0]     start_step_ff, start_step_in;
   logic [STEP_W-1:0]     end_step_ff, end_step_in;
   logic [LFSR_W-1:0]     lfsr_ff, lfsr_in;
   logic signed [NOISE_W-1:0] held_ff, held_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;

   // per item working registers
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [LEN_W-1:0]    k_ff, k_in;
   logic [LFSR_W-1:0]   habs_ff, habs_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [AMP_W-1:0]    mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic                work_last_ff, work_last_in;
   logic                work_active_ff, work_active_in;

   // output register
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       last_out_ff, last_out_in;
   logic                       active_out_ff, active_out_in;

   logic [LEN_W-1:0]    len;
   logic                idx_below;
   logic [LEN_W-1:0]    rem;
   logic [LEN_W-1:0]    k_clamp;
   logic [LEN_W:0]      idx_inc;
   logic                last_hit;
   kind_type            kind;

   logic [STEP_W+PHASE_BITS-1:0] start_wide;
   logic [STEP_W+PHASE_BITS-1:0] glide_wide;
   logic [PHASE_BITS-1:0]        phase_const;
   logic [PHASE_BITS-1:0]        phase_glide;
   logic                         glide_up;
   logic [STEP_W-1:0]            glide_diff;
   logic [STEP_W-1:0]            glide_step;

   logic [LFSR_W-1:0]         lfsr_step;
   logic signed [NOISE_W:0]   draw_wide;
   logic signed [NOISE_W-1:0] held_draw;
   logic signed [NOISE_W-1:0] held_use;
   logic signed [NOISE_W-1:0] held_abs;
   logic [HOLD_W:0]           hold_sum;
   logic [HOLD_W-1:0]         hold_next;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [DVS_W-1:0]    divisor;
   logic                div_done;
   logic [QUO_W-1:0]    div_q;
   logic signed [SAMPLE_W-1:0] mag_s;

   function automatic logic square_high(input logic [PHASE_BITS-1:0] ph,
                                        input logic [DUTY_W-1:0] d);
      return {1'b0, ph[PHASE_BITS-1 -: DUTY_FRAC_W]} < d;
   endfunction

   // envelope terms
   assign len       = (note_len_ff == '0) ? LEN_W'(1) : note_len_ff;
   assign idx_below = idx_ff < len;
   assign rem       = idx_below ? (len - idx_ff) : '0;
   assign k_clamp   = idx_below ? idx_ff : len;
   assign idx_inc   = {1'b0, idx_ff} + (LEN_W + 1)'(1);
   assign last_hit  = idx_inc >= {1'b0, len};

   always_comb begin
      case (mode_ff)
         MODE_GLIDE: kind = KIND_GLIDE;
         MODE_NOISE: kind = KIND_NOISE;
         default:    kind = KIND_CONST;
      endcase
   end

   // phase
   assign start_wide  = {{PHASE_BITS{1'b0}}, start_step_ff};
   assign phase_const = phase_ff + start_wide[PHASE_BITS-1:0];
   assign glide_up    = end_step_ff >= start_step_ff;
   assign glide_diff  = glide_up ? (end_step_ff - start_step_ff)
                                 : (start_step_ff - end_step_ff);
   assign glide_step  = glide_up ? (start_step_ff + div_q) : (start_step_ff - div_q);
   assign glide_wide  = {{PHASE_BITS{1'b0}}, glide_step};
   assign phase_glide = phase_ff + glide_wide[PHASE_BITS-1:0];

   // noise
   assign lfsr_step = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);
   assign draw_wide = $signed({2'b00, lfsr_step}) + $signed({2'b00, lfsr_step})
                      - $signed(NOISE_FULL);
   assign held_draw = draw_wide[NOISE_W-1:0];
   assign held_use  = (hold_ff == '0) ? held_draw : held_ff;
   assign held_abs  = held_use[NOISE_W-1] ? -held_use : held_use;
   assign hold_sum  = {1'b0, hold_ff} + (HOLD_W + 1)'(1);
   assign hold_next = (hold_sum >= (HOLD_W + 1)'(NOISE_HOLD)) ? '0 : hold_sum[HOLD_W-1:0];

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_GLIDE: begin
            mul_a = MUL_A_W'(glide_diff);
            mul_b = k_ff;
         end
         MUL_NOISE_AMP: begin
            mul_a = MUL_A_W'(habs_ff);
            mul_b = MUL_B_W'(amp_ff);
         end
         MUL_PROD_REM: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = rem_ff;
         end
         default: begin
            mul_a = MUL_A_W'(amp_ff);
            mul_b = rem_ff;
         end
      endcase
   end

   assign divisor = cmd.div_scaled ? (DVS_W'({len, 16'h0000}) - DVS_W'(len)) : DVS_W'(len);
   assign mag_s   = {1'b0, mag_ff};

   always_comb begin
      mode_in        = mode_ff;
      duty_in        = duty_ff;
      amp_in         = amp_ff;
      note_len_in    = note_len_ff;
      seed_in        = seed_ff;
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      playing_in     = playing_ff;
      start_step_in  = start_step_ff;
      end_step_in    = end_step_ff;
      lfsr_in        = lfsr_ff;
      held_in        = held_ff;
      hold_in        = hold_ff;
      rem_in         = rem_ff;
      k_in           = k_ff;
      habs_in        = habs_ff;
      prod_in        = prod_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      work_last_in   = work_last_ff;
      work_active_in = work_active_ff;
      sample_in      = sample_ff;
      last_out_in    = last_out_ff;
      active_out_in  = active_out_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE:        mode_in     = csr_wdata[MODE_W-1:0];
            CSR_DUTY:        duty_in     = csr_wdata[DUTY_W-1:0];
            CSR_AMPLITUDE:   amp_in      = csr_wdata[AMP_W-1:0];
            CSR_NOTE_LENGTH: note_len_in = csr_wdata[LEN_W-1:0];
            CSR_NOISE_SEED:  seed_in     = csr_wdata[LFSR_W-1:0];
            default: ;
         endcase
      end

      if (cmd.accept_start) begin
         start_step_in = req_start_step;
         end_step_in   = req_end_step;
         phase_in      = '0;
         idx_in        = '0;
         hold_in       = '0;
         held_in       = '0;
         lfsr_in       = (seed_ff == '0) ? LFSR_W'(1) : seed_ff;
         playing_in    = 1'b1;
      end

      if (cmd.accept_tick) begin
         work_active_in = playing_ff;
         work_last_in   = playing_ff & last_hit;
         rem_in         = rem;
         k_in           = k_clamp;
         if (!playing_ff) begin
            mag_in = '0;
            neg_in = 1'b0;
         end else begin
            idx_in = idx_inc[LEN_W-1:0];
            if (last_hit) begin
               playing_in = 1'b0;
            end
            case (kind)
               KIND_NOISE: begin
                  if (hold_ff == '0) begin
                     lfsr_in = lfsr_step;
                     held_in = held_draw;
                  end
                  hold_in = hold_next;
                  neg_in  = held_use[NOISE_W-1];
                  habs_in = held_abs[LFSR_W-1:0];
               end
               KIND_GLIDE: ;
               default: begin
                  neg_in   = ~square_high(phase_ff, duty_ff);
                  phase_in = phase_const;
               end
            endcase
         end
      end

      if (cmd.mul_en) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      if (cmd.glide_add) begin
         phase_in = phase_glide;
         neg_in   = ~square_high(phase_glide, duty_ff);
      end

      if (cmd.load_mag) begin
         mag_in = div_q[AMP_W-1:0];
      end

      if (cmd.out_load) begin
         sample_in     = neg_ff ? -mag_s : mag_s;
         last_out_in   = work_last_ff;
         active_out_in = work_active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESET;
         duty_ff       <= DUTY_RESET;
         amp_ff        <= AMP_RESET;
         note_len_ff   <= LEN_RESET;
         seed_ff       <= SEED_RESET;
         phase_ff      <= '0;
         idx_ff        <= '0;
         playing_ff    <= 1'b0;
         start_step_ff <= '0;
         end_step_ff   <= '0;
         lfsr_ff       <= LFSR_RESET;
         held_ff       <= '0;
         hold_ff       <= '0;
      end else begin
         mode_ff       <= mode_in;
         duty_ff       <= duty_in;
         amp_ff        <= amp_in;
         note_len_ff   <= note_len_in;
         seed_ff       <= seed_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         playing_ff    <= playing_in;
         start_step_ff <= start_step_in;
         end_step_ff   <= end_step_in;
         lfsr_ff       <= lfsr_in;
         held_ff       <= held_in;
         hold_ff       <= hold_in;
      end
      rem_ff         <= rem_in;
      k_ff           <= k_in;
      habs_ff        <= habs_in;
      prod_ff        <= prod_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      work_last_ff   <= work_last_in;
      work_active_ff <= work_active_in;
      sample_ff      <= sample_in;
      last_out_ff    <= last_out_in;
      active_out_ff  <= active_out_in;
   end

   sqs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign status.playing  = playing_ff;
   assign status.kind     = kind;
   assign status.div_done = div_done;

   assign rsp_sample       = sample_ff;
   assign rsp_last_of_note = last_out_ff;
   assign rsp_active       = active_out_ff;

endmodule

// ===== rtl/sqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqs_ctrl
// Sequencer: takes one item at a time, steps the datapath through the
// multiply and divide passes and owns the result valid.
// ----------------------------------------------------------------------------
module sqs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output sqs_pkg::dp_cmd_type    cmd,
   input  sqs_pkg::dp_status_type status
);
   import sqs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_G,
      S_DIV_G,
      S_WAIT_G,
      S_MUL_N1,
      S_MUL_N2,
      S_MUL_A,
      S_DIV_M,
      S_WAIT_M,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      noise_ff, noise_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      noise_in     = noise_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_START) begin
                  cmd.accept_start = 1'b1;
               end else begin
                  cmd.accept_tick = 1'b1;
                  noise_in        = (status.kind == KIND_NOISE);
                  if (!status.playing) begin
                     state_in = S_OUT;
                  end else begin
                     case (status.kind)
                        KIND_GLIDE: state_in = S_MUL_G;
                        KIND_NOISE: state_in = S_MUL_N1;
                        default:    state_in = S_MUL_A;
                     endcase
                  end
               end
            end
         end
         S_MUL_G: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GLIDE;
            state_in    = S_DIV_G;
         end
         S_DIV_G: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT_G;
         end
         S_WAIT_G: begin
            if (status.div_done) begin
               cmd.glide_add = 1'b1;
               state_in      = S_MUL_A;
            end
         end
         S_MUL_N1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_NOISE_AMP;
            state_in    = S_MUL_N2;
         end
         S_MUL_N2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PROD_REM;
            state_in    = S_DIV_M;
         end
         S_MUL_A: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AMP_REM;
            state_in    = S_DIV_M;
         end
         S_DIV_M: begin
            cmd.div_start  = 1'b1;
            cmd.div_scaled = noise_ff;
            state_in       = S_WAIT_M;
         end
         S_WAIT_M: begin
            if (status.div_done) begin
               cmd.load_mag = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         noise_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         noise_ff     <= noise_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_WAIT_G || state_ff == S_WAIT_M))
      else $error("divider finished outside a wait state");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while item pending");
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_TICK && status.playing) |=>
         (state_ff != S_IDLE && state_ff != S_OUT))
      else $error("playing tick did not start the datapath");
`endif

endmodule

// ===== rtl/square_sweep_noise_clip_synth.sv =====
// ----------------------------------------------------------------------------
// square_sweep_noise_clip_synth
// Square tone, pitch glide and held noise clip generator with linear decay.
//
// req channel: command 1 starts a note (start_step, end_step), command 0 is a
// sample tick. Each tick gives exactly one rsp item; a start gives none.
// csr port: write mode, duty, amplitude, note_length, noise_seed by index;
// writes take effect at once and are expected only while the block is idle.
// One item is in work at a time. A start command is taken in the idle state
// and gives no result. A tick with no note playing goes straight to the
// output state. Tone and noise ticks pass once through a bit-serial divider
// for the magnitude, which sets the rate; glide mode runs it twice per
// sample, once for the glide step and once for the magnitude.
// The result sits in an output register; a new item is accepted while it
// waits, and a finished item is held until rsp.ready frees the register.
// Reset (synchronous) restores the register defaults, stops any note and
// empties the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module square_sweep_noise_clip_synth #(
   parameter int unsigned NOISE_HOLD = sqs_pkg::NOISE_HOLD_DEF,
   parameter int unsigned PHASE_BITS = sqs_pkg::PHASE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   sqs_req_if.sink                         req,
   sqs_rsp_if.source                       rsp,
   input  logic                            csr_write_en,
   input  logic [sqs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sqs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sqs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sqs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_command (req.command),
      .req_ready   (req.ready),
      .rsp_ready   (rsp.ready),
      .rsp_valid   (rsp.valid),
      .cmd         (cmd),
      .status      (status)
   );

   sqs_dp #(
      .NOISE_HOLD (NOISE_HOLD),
      .PHASE_BITS (PHASE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_start_step   (req.start_step),
      .req_end_step     (req.end_step),
      .cmd              (cmd),
      .status           (status),
      .rsp_sample       (rsp.sample),
      .rsp_last_of_note (rsp.last_of_note),
      .rsp_active       (rsp.active)
   );

endmodule

// ===== sim/square_sweep_noise_clip_synth_test.sv =====
// ----------------------------------------------------------------------------
// square_sweep_noise_clip_synth_test
// Self-checking bench for the square, glide and noise clip generator. A queue
// of note starts and sample ticks feeds a valid/ready driver with random gaps.
// Each accepted item runs through a behavioral voice model that holds its own
// copy of the note state and registers. A monitor with random stalls checks
// every sample item against the oldest predicted one. Registers change between
// phases while the block is idle, including a note length shrunk under a
// playing note.
// ----------------------------------------------------------------------------
module square_sweep_noise_clip_synth_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sqs_pkg::*;

   localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned REPORT_MAX  = 10;

   typedef struct packed {
      logic              command;
      logic [STEP_W-1:0] start_step;
      logic [STEP_W-1:0] end_step;
   } cmd_item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_of_note;
      logic                       active;
   } sample_item_type;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sqs_req_if req_ch ();
   sqs_rsp_if rsp_ch ();

   square_sweep_noise_clip_synth u_dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   cmd_item_type    pending_cmds[$];
   sample_item_type expected_samples[$];
   int unsigned  sample_errors;
   int unsigned  quiet_cycles;
   bit           req_gaps_on;
   bit           rsp_stalls_on;
   bit           req_offered;
   int unsigned  req_gap;
   int unsigned  rsp_stall;

   // register copies
   logic [MODE_W-1:0] cfg_mode;
   logic [DUTY_W-1:0] cfg_duty;
   logic [AMP_W-1:0]  cfg_amp;
   logic [LEN_W-1:0]  cfg_len;
   logic [LFSR_W-1:0] cfg_seed;

   // voice state
   logic [STEP_W-1:0] v_phase;
   logic [LEN_W-1:0]  v_index;
   logic              v_playing;
   logic [STEP_W-1:0] v_start_step;
   logic [STEP_W-1:0] v_end_step;
   logic [LFSR_W-1:0] v_lfsr;
   longint            v_held;
   int unsigned       v_hold;

   always #5 clock = ~clock;

   function automatic void voice_step(input cmd_item_type it);
      longint unsigned len, idx, rem, mag, habs, k, span;
      longint          level;
      logic [STEP_W-1:0] step;
      logic neg, last, lsb;
      sample_item_type res;
      if (it.command == CMD_START) begin
         v_start_step = it.start_step;
         v_end_step   = it.end_step;
         v_phase      = '0;
         v_index      = '0;
         v_hold       = 0;
         v_held       = 0;
         v_lfsr       = (cfg_seed != 0) ? cfg_seed : 16'd1;
         v_playing    = 1'b1;
         return;
      end
      res = '0;
      if (v_playing) begin
         len = (cfg_len != 0) ? longint'(cfg_len) : 1;
         idx = v_index;
         rem = (idx < len) ? len - idx : 0;
         if (cfg_mode == MODE_NOISE) begin
            if (v_hold == 0) begin
               lsb = v_lfsr[0];
               v_lfsr = v_lfsr >> 1;
               if (lsb) v_lfsr = v_lfsr ^ LFSR_TAPS;
               v_held = 2 * longint'(v_lfsr) - 65535;
            end
            v_hold = (v_hold + 1 >= NOISE_HOLD_DEF) ? 0 : v_hold + 1;
            neg = v_held < 0;
            habs = neg ? -v_held : v_held;
            mag = (habs * cfg_amp * rem) / (65535 * len);
         end else if (cfg_mode == MODE_GLIDE) begin
            k = (idx < len) ? idx : len;
            if (v_end_step >= v_start_step) begin
               span = v_end_step - v_start_step;
               step = STEP_W'(v_start_step + (span * k) / len);
            end else begin
               span = v_start_step - v_end_step;
               step = STEP_W'(v_start_step - (span * k) / len);
            end
            v_phase = v_phase + step;
            neg = !(v_phase[STEP_W-1 -: DUTY_FRAC_W] < cfg_duty);
            mag = (cfg_amp * rem) / len;
         end else begin
            neg = !(v_phase[STEP_W-1 -: DUTY_FRAC_W] < cfg_duty);
            v_phase = v_phase + v_start_step;
            mag = (cfg_amp * rem) / len;
         end
         level = neg ? -longint'(mag) : longint'(mag);
         last = (idx + 1) >= len;
         v_index = LEN_W'(idx + 1);
         if (last) v_playing = 1'b0;
         res.sample = level[SAMPLE_W-1:0];
         res.last_of_note = last;
         res.active = 1'b1;
      end
      expected_samples.push_back(res);
   endfunction

   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [STEP_W-1:0] rand_step();
      case ($urandom_range(0, 4))
         0: return STEP_W'($urandom());
         1: return STEP_W'($urandom_range(0, 24'h800000));
         2: return STEP_W'($urandom_range(0, 24'h03FFFF));
         3: return 24'h800000;
         default: return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_offered  = 1'b0;
         req_gap      = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            voice_step(pending_cmds.pop_front());
            req_offered = 1'b0;
         end
         if (!req_offered) begin
            if (req_gap == 0 && pending_cmds.size() != 0) begin
               req_ch.valid      <= 1'b1;
               req_ch.command    <= pending_cmds[0].command;
               req_ch.start_step <= pending_cmds[0].start_step;
               req_ch.end_step   <= pending_cmds[0].end_step;
               req_offered = 1'b1;
               req_gap = pick_gap(req_gaps_on);
            end else begin
               req_ch.valid <= 1'b0;
               if (req_gap != 0) req_gap = req_gap - 1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sample_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_samples.size() == 0) begin
               if (sample_errors < REPORT_MAX)
                  $display("unexpected sample item: %0d last %0b active %0b",
                           rsp_ch.sample, rsp_ch.last_of_note, rsp_ch.active);
               sample_errors = sample_errors + 1;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_ch.sample !== want.sample ||
                   rsp_ch.last_of_note !== want.last_of_note ||
                   rsp_ch.active !== want.active) begin
                  if (sample_errors < REPORT_MAX)
                     $display("sample mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                              want.sample, want.last_of_note, want.active,
                              rsp_ch.sample, rsp_ch.last_of_note, rsp_ch.active);
                  sample_errors = sample_errors + 1;
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = rsp_stall - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_stall = pick_gap(rsp_stalls_on);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || csr_write_en || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("square_sweep_noise_clip_synth_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_start(input logic [STEP_W-1:0] s, input logic [STEP_W-1:0] e);
      cmd_item_type it;
      it.command = CMD_START;
      it.start_step = s;
      it.end_step = e;
      pending_cmds.push_back(it);
   endtask

   task automatic push_ticks(input int n);
      cmd_item_type it;
      for (int i = 0; i < n; i++) begin
         it.command = CMD_TICK;
         it.start_step = STEP_W'($urandom());
         it.end_step = STEP_W'($urandom());
         pending_cmds.push_back(it);
      end
   endtask

   task automatic settle();
      while (pending_cmds.size() != 0 || expected_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_MODE:        cfg_mode = value[MODE_W-1:0];
         CSR_DUTY:        cfg_duty = value[DUTY_W-1:0];
         CSR_AMPLITUDE:   cfg_amp  = value[AMP_W-1:0];
         CSR_NOTE_LENGTH: cfg_len  = value[LEN_W-1:0];
         CSR_NOISE_SEED:  cfg_seed = value[LFSR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic close_csr();
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_config();
      logic [DUTY_W-1:0] duty;
      logic [AMP_W-1:0]  amp;
      logic [LEN_W-1:0]  len;
      logic [LFSR_W-1:0] seed;
      case ($urandom_range(0, 5))
         0: duty = 9'd0;
         1: duty = 9'd256;
         2: duty = 9'd511;
         3: duty = 9'd255;
         default: duty = DUTY_W'($urandom_range(0, 511));
      endcase
      case ($urandom_range(0, 4))
         0: amp = 15'd0;
         1: amp = 15'd32767;
         default: amp = AMP_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
         0: len = 16'd0;
         1: len = LEN_W'($urandom_range(1000, 65535));
         2: len = 16'd1;
         default: len = LEN_W'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 4))
         0: seed = 16'd0;
         1: seed = 16'hFFFF;
         default: seed = LFSR_W'($urandom());
      endcase
      write_csr(CSR_MODE, CSR_DATA_W'($urandom_range(0, 3)));
      write_csr(CSR_DUTY, CSR_DATA_W'(duty));
      write_csr(CSR_AMPLITUDE, CSR_DATA_W'(amp));
      write_csr(CSR_NOTE_LENGTH, len);
      write_csr(CSR_NOISE_SEED, seed);
      close_csr();
   endtask

   // notes with random content, now and then cut short by a restart
   task automatic play_notes(input int n_items);
      int left, run, len_eff;
      left = n_items;
      len_eff = (cfg_len != 0) ? int'(cfg_len) : 1;
      while (left > 0) begin
         push_start(rand_step(), rand_step());
         left = left - 1;
         if ($urandom_range(0, 9) == 0) run = $urandom_range(0, len_eff);
         else run = $urandom_range(len_eff, len_eff + 2);
         if (run > left) run = left;
         push_ticks(run);
         left = left - run;
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_TICK;
      req_ch.start_step = '0;
      req_ch.end_step = '0;
      rsp_ch.ready = 1'b0;
      sample_errors = 0;
      quiet_cycles = 0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      cfg_mode = MODE_RESET;
      cfg_duty = DUTY_RESET;
      cfg_amp  = AMP_RESET;
      cfg_len  = LEN_RESET;
      cfg_seed = SEED_RESET;
      v_phase = '0;
      v_index = '0;
      v_playing = 1'b0;
      v_start_step = '0;
      v_end_step = '0;
      v_lfsr = LFSR_RESET;
      v_held = 0;
      v_hold = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // idle tick, then a note under reset registers at the fastest pitch
      push_ticks(1);
      push_start(24'h800000, 24'h000000);
      push_ticks(3);
      settle();

      // length shrunk under the playing note: zero envelope and note end
      write_csr(CSR_AMPLITUDE, 16'd32767);
      write_csr(CSR_NOTE_LENGTH, 16'd2);
      close_csr();
      push_ticks(2);
      settle();

      // mode three with duty above full scale
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_ALIAS));
      write_csr(CSR_DUTY, 16'd256);
      write_csr(CSR_NOTE_LENGTH, 16'd3);
      close_csr();
      push_start(24'h123456, 24'hFFFFFF);
      push_ticks(3);
      settle();

      // glide up, restarted mid note by a glide down
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_GLIDE));
      write_csr(CSR_DUTY, 16'd0);
      close_csr();
      push_start(24'h000000, 24'hFFFFFF);
      push_ticks(2);
      push_start(24'hFFFFFF, 24'h000000);
      push_ticks(2);
      settle();

      // noise with zero seed and zero length
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_NOISE));
      write_csr(CSR_NOISE_SEED, 16'd0);
      write_csr(CSR_NOTE_LENGTH, 16'd0);
      close_csr();
      push_start(rand_step(), rand_step());
      push_ticks(2);
      settle();

      // noise past one hold period
      write_csr(CSR_NOISE_SEED, 16'hFFFF);
      write_csr(CSR_NOTE_LENGTH, 16'd9);
      close_csr();
      push_start(rand_step(), rand_step());
      push_ticks(9);
      settle();

      for (int p = 0; p < 8; p++) begin
         req_gaps_on   = (p != 0) && (p != 2);
         rsp_stalls_on = (p != 0) && (p != 1);
         random_config();
         play_notes(45);
         settle();
      end

      // extremes: silent long glide, then full scale minimum length tone
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_GLIDE));
      write_csr(CSR_DUTY, 16'd511);
      write_csr(CSR_AMPLITUDE, 16'd0);
      write_csr(CSR_NOTE_LENGTH, 16'd65535);
      write_csr(CSR_NOISE_SEED, 16'd1);
      close_csr();
      play_notes(20);
      settle();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_CONST));
      write_csr(CSR_AMPLITUDE, 16'd32767);
      write_csr(CSR_NOTE_LENGTH, 16'd1);
      close_csr();
      play_notes(20);
      settle();

      repeat (60) @(posedge clock);
      if (sample_errors == 0 && expected_samples.size() == 0) begin
         $display("square_sweep_noise_clip_synth_test: PASS");
      end else begin
         $display("square_sweep_noise_clip_synth_test: FAIL");
      end
      $finish;
   end

endmodule
